// File: src/key_click_gesture_detector_top_defines.svh
// Assertion macros used by the key gesture detector merge stage.
`ifndef KEY_CLICK_GESTURE_DETECTOR_TOP_DEFINES_SVH
`define KEY_CLICK_GESTURE_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on clk, idle while arst_n is low.
`define KCGD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("kcgd assertion failed");
// Check a property on clk at every edge, reset included.
`define KCGD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("kcgd assertion failed");
`else
`define KCGD_ASSERT(lbl, prop)
`define KCGD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: src/kcgd_pkg.sv
// Types and constants of the key gesture detector.
`default_nettype none

package kcgd_pkg;

	localparam int NUM_KEYS = 4;
	localparam int KEY_W    = 2;

	// input and output field layout
	localparam int LEVELS_W = 4;
	localparam int TICK_W   = 32;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd2;
	localparam int CFG_DATA_W = 16;

	localparam logic [3:0]  DEBOUNCE_RST     = 4'd3;
	localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic [15:0] DOUBLE_CLICK_RST = 16'd400;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_CLICK  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	typedef enum logic [3:0] {
		PH_IDLE         = 4'b0001,
		PH_PRESSED      = 4'b0010,
		PH_WAIT_SECOND  = 4'b0100,
		PH_WAIT_RELEASE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [3:0]  debounce;
		logic [15:0] long_ticks;
		logic [15:0] double_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// File: src/kcgd_lane.sv
// One key lane: debounce counter and four-phase gesture machine.
`default_nettype none

module kcgd_lane (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kcgd_pkg::cfg_t                    cfg,
	input  wire logic                              level,    // pin level, 0 is pressed
	input  wire logic [kcgd_pkg::TICK_W-1:0]       now_tick,
	input  wire logic                              commit,   // take the next state
	output kcgd_pkg::event_t                       ev
);

	logic                          last_q;
	logic [3:0]                    cnt_q;
	kcgd_pkg::phase_t              phase_q;
	logic                          long_q;
	logic [kcgd_pkg::TICK_W-1:0]   mark_q;

	logic                          pressed;
	logic [3:0]                    cnt_n;
	logic                          stable;
	logic [kcgd_pkg::TICK_W-1:0]   elapsed;
	kcgd_pkg::phase_t              phase_n;
	logic                          long_n;
	logic [kcgd_pkg::TICK_W-1:0]   mark_n;

	// count equal samples, saturating at the debounce setting
	assign pressed = ~level;
	always_comb begin
		if (pressed == last_q) begin
			cnt_n = (cnt_q < cfg.debounce) ? cnt_q + 4'd1 : cnt_q;
		end else begin
			cnt_n = 4'd0;
		end
	end
	assign stable  = !(cnt_n < cfg.debounce);
	assign elapsed = now_tick - mark_q;

	// advance the gesture machine on a stable level
	always_comb begin
		phase_n = phase_q;
		long_n  = long_q;
		mark_n  = mark_q;
		ev      = kcgd_pkg::EV_NONE;
		if (stable) begin
			case (phase_q)
				kcgd_pkg::PH_IDLE: begin
					if (pressed) begin
						phase_n = kcgd_pkg::PH_PRESSED;
						mark_n  = now_tick;
						long_n  = 1'b0;
					end
				end
				kcgd_pkg::PH_PRESSED: begin
					if (!pressed) begin
						if (long_q) begin
							phase_n = kcgd_pkg::PH_WAIT_RELEASE;
						end else begin
							phase_n = kcgd_pkg::PH_WAIT_SECOND;
							mark_n  = now_tick;
						end
					end else if (!long_q &&
							elapsed >= {16'd0, cfg.long_ticks}) begin
						long_n = 1'b1;
						ev     = kcgd_pkg::EV_LONG;
					end
				end
				kcgd_pkg::PH_WAIT_SECOND: begin
					if (pressed) begin
						phase_n = kcgd_pkg::PH_WAIT_RELEASE;
						ev      = kcgd_pkg::EV_DOUBLE;
					end else if (elapsed >= {16'd0, cfg.double_ticks}) begin
						phase_n = kcgd_pkg::PH_IDLE;
						ev      = kcgd_pkg::EV_CLICK;
					end
				end
				kcgd_pkg::PH_WAIT_RELEASE: begin
					if (!pressed) begin
						phase_n = kcgd_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_n = kcgd_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// hold the key state until the scan reaches this lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			cnt_q   <= 4'd0;
			phase_q <= kcgd_pkg::PH_IDLE;
			long_q  <= 1'b0;
			mark_q  <= '0;
		end else if (commit) begin
			last_q  <= pressed;
			cnt_q   <= cnt_n;
			phase_q <= phase_n;
			long_q  <= long_n;
			mark_q  <= mark_n;
		end
	end

endmodule

`default_nettype wire

// File: src/kcgd_merge.sv
// Priority merge of lane events and the registered result stage.
`default_nettype none

`include "key_click_gesture_detector_top_defines.svh"

module kcgd_merge (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire kcgd_pkg::event_t [kcgd_pkg::NUM_KEYS-1:0] lane_ev,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	output logic [kcgd_pkg::NUM_KEYS-1:0]               commit,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output kcgd_pkg::event_t                            out_code,
	output logic [kcgd_pkg::KEY_W-1:0]                  out_key
);

	logic                          accept;
	logic                          blocked;
	kcgd_pkg::event_t              code;
	logic [kcgd_pkg::KEY_W-1:0]    idx;
	logic                          valid_q;
	kcgd_pkg::event_t              code_q;
	logic [kcgd_pkg::KEY_W-1:0]    key_q;

	// take a new scan whenever the result slot frees up this cycle
	assign in_ready = !valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// stop at the first lane that fires; commit it and the lanes before it
	always_comb begin
		blocked = 1'b0;
		code    = kcgd_pkg::EV_NONE;
		idx     = '0;
		commit  = '0;
		for (int i = 0; i < kcgd_pkg::NUM_KEYS; i++) begin
			commit[i] = accept && !blocked;
			if (!blocked && lane_ev[i] != kcgd_pkg::EV_NONE) begin
				code    = lane_ev[i];
				idx     = kcgd_pkg::KEY_W'(i);
				blocked = 1'b1;
			end
		end
	end

	// hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= code;
			key_q  <= idx;
		end
	end

	assign out_valid = valid_q;
	assign out_code  = code_q;
	assign out_key   = key_q;

	`KCGD_ASSERT_ALWAYS(a_commit_needs_accept, !accept |-> commit == '0)
	`KCGD_ASSERT_ALWAYS(a_commit_prefix,
		(commit & (commit + kcgd_pkg::NUM_KEYS'(1))) == '0)
	`KCGD_ASSERT(a_accept_gives_result, accept |=> valid_q)
	`KCGD_ASSERT(a_none_has_key_zero,
		valid_q && code_q == kcgd_pkg::EV_NONE |-> key_q == '0)

endmodule

`default_nettype wire

// File: src/key_click_gesture_detector_top.sv
// Top level of the four-key click, double click and long press detector.
`default_nettype none

// Each scan on the s_ stream carries the raw active-low levels of four keys
// and a tick count; each produces exactly one result on the m_ stream with
// an event code (none, click, double click, long press) and the key index.
// For each scan, four key lanes evaluate debounce and gesture
// state side by side and a priority merge picks the lowest key that fires,
// updating only that key and the ones before it. Scans are taken every cycle
// while the result register is empty or being read. Configuration writes
// (index 0 debounce count, 1 long press ticks, 2 double click ticks) are
// taken every cycle; unknown indexes are ignored.
module key_click_gesture_detector_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [kcgd_pkg::IN_W-1:0]           s_tdata,   // raw_levels[3:0], now_tick[35:4]
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [kcgd_pkg::OUT_W-1:0]               m_tdata,   // event_code[1:0], key_index[3:2]
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [kcgd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kcgd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	kcgd_pkg::cfg_t                                   cfg_q;
	logic [kcgd_pkg::LEVELS_W-1:0]                    raw_levels;
	logic [kcgd_pkg::TICK_W-1:0]                      now_tick;
	kcgd_pkg::event_t [kcgd_pkg::NUM_KEYS-1:0]        lane_ev;
	logic [kcgd_pkg::NUM_KEYS-1:0]                    commit;
	kcgd_pkg::event_t                                 out_code;
	logic [kcgd_pkg::KEY_W-1:0]                       out_key;

	// write configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce     <= kcgd_pkg::DEBOUNCE_RST;
			cfg_q.long_ticks   <= kcgd_pkg::LONG_PRESS_RST;
			cfg_q.double_ticks <= kcgd_pkg::DOUBLE_CLICK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				kcgd_pkg::REG_DEBOUNCE:     cfg_q.debounce     <= cfg_data[3:0];
				kcgd_pkg::REG_LONG_PRESS:   cfg_q.long_ticks   <= cfg_data;
				kcgd_pkg::REG_DOUBLE_CLICK: cfg_q.double_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// unpack the scan
	assign raw_levels = s_tdata[kcgd_pkg::LEVELS_W-1:0];
	assign now_tick   = s_tdata[kcgd_pkg::LEVELS_W +: kcgd_pkg::TICK_W];

	// one lane per key
	for (genvar g = 0; g < kcgd_pkg::NUM_KEYS; g++) begin : g_lane
		kcgd_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.level    (raw_levels[g]),
			.now_tick (now_tick),
			.commit   (commit[g]),
			.ev       (lane_ev[g])
		);
	end

	kcgd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lane_ev   (lane_ev),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.commit    (commit),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (out_code),
		.out_key   (out_key)
	);

	// pack the result
	assign m_tdata = {4'd0, out_key, out_code};

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the key click gesture detector: directed and random scans.
module tb;

	localparam logic [kcgd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		kcgd_pkg::event_t code;
		logic [1:0]       key;
	} gesture_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [kcgd_pkg::IN_W-1:0]       s_tdata   = '0;   // raw_levels[3:0], now_tick[35:4]
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [kcgd_pkg::OUT_W-1:0]      m_tdata;          // event_code[1:0], key_index[3:2]
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [kcgd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [kcgd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	key_click_gesture_detector_top u_top (.*);

	// Gesture predictor state and its copy of the registers
	logic [3:0]        cfg_debounce;
	logic [15:0]       cfg_long;
	logic [15:0]       cfg_double;
	logic              was_pressed [kcgd_pkg::NUM_KEYS];
	logic [3:0]        stable_cnt  [kcgd_pkg::NUM_KEYS];
	kcgd_pkg::phase_t  key_phase   [kcgd_pkg::NUM_KEYS];
	logic              long_done   [kcgd_pkg::NUM_KEYS];
	logic [31:0]       mark        [kcgd_pkg::NUM_KEYS];

	gesture_t    expected_events [$];
	int          mismatches      = 0;
	int          scans_sent      = 0;
	int          results_checked = 0;
	int          event_seen [4]  = '{default: 0};

	// Stimulus knobs
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int          hold_left      = 0;
	int unsigned tick_step_max  = 1;
	logic [3:0]  run_level      = 4'hF;
	int          run_left [kcgd_pkg::NUM_KEYS] = '{default: 0};
	logic [31:0] tick_now       = 32'hFFFF_FFB0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Generous bound on the whole run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic void reset_predictor();
		cfg_debounce = kcgd_pkg::DEBOUNCE_RST;
		cfg_long     = kcgd_pkg::LONG_PRESS_RST;
		cfg_double   = kcgd_pkg::DOUBLE_CLICK_RST;
		for (int k = 0; k < kcgd_pkg::NUM_KEYS; k++) begin
			was_pressed[k] = 1'b0;
			stable_cnt[k]  = '0;
			key_phase[k]   = kcgd_pkg::PH_IDLE;
			long_done[k]   = 1'b0;
			mark[k]        = '0;
		end
	endfunction

	// Debounce each key in index order and stop at the first one that fires
	function automatic gesture_t predict_gesture(logic [3:0] levels, logic [31:0] now);
		gesture_t    res;
		logic        pressed;
		logic [31:0] elapsed;
		res.code = kcgd_pkg::EV_NONE;
		res.key  = '0;
		for (int k = 0; k < kcgd_pkg::NUM_KEYS; k++) begin
			pressed = ~levels[k];
			if (pressed == was_pressed[k]) begin
				if (stable_cnt[k] < cfg_debounce)
					stable_cnt[k]++;
			end else begin
				stable_cnt[k] = '0;
			end
			was_pressed[k] = pressed;
			if (stable_cnt[k] < cfg_debounce)
				continue;
			elapsed = now - mark[k];
			case (key_phase[k])
				kcgd_pkg::PH_IDLE: begin
					if (pressed) begin
						key_phase[k] = kcgd_pkg::PH_PRESSED;
						mark[k]      = now;
						long_done[k] = 1'b0;
					end
				end
				kcgd_pkg::PH_PRESSED: begin
					if (!pressed) begin
						if (long_done[k]) begin
							key_phase[k] = kcgd_pkg::PH_WAIT_RELEASE;
						end else begin
							key_phase[k] = kcgd_pkg::PH_WAIT_SECOND;
							mark[k]      = now;
						end
					end else if (!long_done[k] && elapsed >= 32'(cfg_long)) begin
						long_done[k] = 1'b1;
						res.code     = kcgd_pkg::EV_LONG;
					end
				end
				kcgd_pkg::PH_WAIT_SECOND: begin
					if (pressed) begin
						key_phase[k] = kcgd_pkg::PH_WAIT_RELEASE;
						res.code     = kcgd_pkg::EV_DOUBLE;
					end else if (elapsed >= 32'(cfg_double)) begin
						key_phase[k] = kcgd_pkg::PH_IDLE;
						res.code     = kcgd_pkg::EV_CLICK;
					end
				end
				default: begin
					if (!pressed)
						key_phase[k] = kcgd_pkg::PH_IDLE;
				end
			endcase
			if (res.code != kcgd_pkg::EV_NONE) begin
				res.key = 2'(k);
				return res;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Offer one scan, with random idle cycles ahead of it; return at a falling edge
	task automatic send_scan(input logic [3:0] levels, input logic [31:0] tick);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, tick, levels};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_events.push_back(predict_gesture(levels, tick));
		scans_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected result has come back
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [kcgd_pkg::CFG_IDX_W-1:0] idx,
			input logic [kcgd_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			kcgd_pkg::REG_DEBOUNCE:     cfg_debounce = data[3:0];
			kcgd_pkg::REG_LONG_PRESS:   cfg_long     = data;
			kcgd_pkg::REG_DOUBLE_CLICK: cfg_double   = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Next scan: each key holds a level for a run of scans, with bounces and noise mixed in
	task automatic make_scan(output logic [3:0] levels, output logic [31:0] tick);
		if ($urandom_range(99) < 8) begin
			levels   = 4'($urandom);
			tick_now = tick_now + $urandom;
		end else begin
			for (int k = 0; k < kcgd_pkg::NUM_KEYS; k++) begin
				if (run_left[k] == 0) begin
					run_level[k] = ~run_level[k];
					if ($urandom_range(9) == 0)
						run_left[k] = $urandom_range(1, 2);
					else if (run_level[k])
						run_left[k] = int'(cfg_debounce) + 1 + $urandom_range(0, 25);
					else
						run_left[k] = int'(cfg_debounce) + 1 + $urandom_range(0, 12);
				end
				run_left[k]--;
			end
			levels   = run_level;
			tick_now = tick_now + $urandom_range(0, tick_step_max);
		end
		tick = tick_now;
	endtask

	task automatic run_random_phase(input logic [kcgd_pkg::CFG_DATA_W-1:0] deb,
			input logic [15:0] long_t, input logic [15:0] dbl_t,
			input int unsigned step_lim, input int unsigned idle_pct,
			input int unsigned stall_pct, input int count);
		logic [3:0]  levels;
		logic [31:0] tick;
		wait_results_drained();
		write_reg(kcgd_pkg::REG_DEBOUNCE, deb);
		write_reg(kcgd_pkg::REG_LONG_PRESS, long_t);
		write_reg(kcgd_pkg::REG_DOUBLE_CLICK, dbl_t);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		tick_step_max  = step_lim;
		for (int i = 0; i < count; i++) begin
			make_scan(levels, tick);
			send_scan(levels, tick);
		end
	endtask

	// Unknown index is dropped; set a tiny debounce and short timeouts
	task automatic test_register_writes();
		wait_results_drained();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(kcgd_pkg::REG_DEBOUNCE, 16'd0);
		write_reg(kcgd_pkg::REG_LONG_PRESS, 16'd5);
		write_reg(kcgd_pkg::REG_DOUBLE_CLICK, 16'd3);
	endtask

	// Long press across tick wrap, double click, click, then all keys at once
	task automatic test_directed_gestures();
		send_scan(4'hF, 32'hFFFF_FFFE);
		send_scan(4'hE, 32'hFFFF_FFFF);
		send_scan(4'hE, 32'd2);
		send_scan(4'hE, 32'd4);
		send_scan(4'hF, 32'd5);
		send_scan(4'hF, 32'd6);
		send_scan(4'hE, 32'd7);
		send_scan(4'hF, 32'd8);
		send_scan(4'hE, 32'd9);
		send_scan(4'hF, 32'd10);
		send_scan(4'hE, 32'd11);
		send_scan(4'hF, 32'd12);
		send_scan(4'hF, 32'd20);
		send_scan(4'h0, 32'd0);
		send_scan(4'h0, 32'h8000_0000);
		send_scan(4'h0, 32'h8000_0000);
		send_scan(4'h0, 32'hFFFF_FFFF);
		send_scan(4'h0, 32'hFFFF_FFFF);
		send_scan(4'hF, 32'd0);
		send_scan(4'hF, 32'd0);
	endtask

	// Both timeouts at zero expire at the first stable check
	task automatic test_zero_timeouts();
		wait_results_drained();
		write_reg(kcgd_pkg::REG_LONG_PRESS, 16'd0);
		write_reg(kcgd_pkg::REG_DOUBLE_CLICK, 16'd0);
		send_scan(4'hB, 32'd50);
		send_scan(4'hF, 32'd51);
		send_scan(4'hF, 32'd51);
		send_scan(4'hB, 32'd60);
		send_scan(4'hB, 32'd60);
	endtask

	// Upper data bits of the debounce write are dropped; ticks wrap early on
	task automatic test_fast_keys();
		run_random_phase({12'hABC, 4'd1}, 16'd12, 16'd6, 3, 0, 0, 110);
	endtask

	task automatic test_reset_timing_sender_gaps();
		run_random_phase(16'(kcgd_pkg::DEBOUNCE_RST), kcgd_pkg::LONG_PRESS_RST,
			kcgd_pkg::DOUBLE_CLICK_RST, 250, 87, 0, 110);
	endtask

	task automatic test_max_settings_receiver_stalls();
		run_random_phase(16'd15, 16'hFFFF, 16'hFFFF, 12000, 0, 87, 110);
	endtask

	task automatic test_min_settings_both_idle();
		run_random_phase(16'd0, 16'd1, 16'd1, 2, 30, 30, 110);
	endtask

	// Long receiver hold-off fills the block; then a full drain mid-stream
	task automatic test_backpressure();
		logic [3:0]  levels;
		logic [31:0] tick;
		run_random_phase(16'd2, 16'd40, 16'd20, 8, 0, 0, 40);
		s_tvalid <= 1'b0;
		@(posedge clk);
		hold_left = HOLD_OFF_CYCLES;
		@(negedge clk);
		for (int i = 0; i < 20; i++) begin
			make_scan(levels, tick);
			send_scan(levels, tick);
		end
		wait_results_drained();
		for (int i = 0; i < 50; i++) begin
			make_scan(levels, tick);
			send_scan(levels, tick);
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		gesture_t want;
		if (m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", m_tdata));
			end else begin
				want = expected_events.pop_front();
				if (m_tdata[1:0] != want.code)
					report_mismatch($sformatf("event_code %0d, expected %0d",
						m_tdata[1:0], want.code));
				if (m_tdata[3:2] != want.key)
					report_mismatch($sformatf("key_index %0d, expected %0d",
						m_tdata[3:2], want.key));
				event_seen[int'(want.code)]++;
				results_checked++;
			end
		end
	end

	initial begin
		reset_predictor();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_register_writes();
		test_directed_gestures();
		test_zero_timeouts();
		test_fast_keys();
		test_reset_timing_sender_gaps();
		test_max_settings_receiver_stalls();
		test_min_settings_both_idle();
		test_backpressure();
		wait_results_drained();
		repeat (8) @(posedge clk);
		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_events.size()));
		$display("Run covered %0d scans and %0d checked results over seven register settings.",
			scans_sent, results_checked);
		$display("Events: %0d none, %0d click, %0d double click, %0d long press; %0d mismatches.",
			event_seen[0], event_seen[1], event_seen[2], event_seen[3], mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
